/* rtl/core/swmc_pkg.sv */
// shared constants and types for the sliding window median cost block
`timescale 1ns / 1ps
package swmc_pkg;
    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_W        = 7;
    localparam int SAMPLE_W     = 30;
    localparam int COST_W       = 36;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DROP,
        S_INSERT,
        S_LOAD,
        S_SCAN,
        S_MUL,
        S_SUB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic drop;
        logic insert;
        logic load;
        logic step;
        logic mul;
        logic sub;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic scan_done;
        logic out_busy;
    } t_status;
endpackage

/* rtl/core/swmc_ctrl.sv */
// sequencer for one sample: ring read, drop, insert, scan, cost
`timescale 1ns / 1ps
module swmc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  swmc_pkg::t_status i_status,
    output logic             o_in_ready,
    output swmc_pkg::t_cmd   o_cmd
);
    import swmc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DROP;
            end
            S_DROP: begin
                o_cmd.drop = i_status.full;
                n_state    = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                // no beat until the window has filled
                if (i_status.full) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

/* rtl/core/swmc_datapath.sv */
// ring memory, sorted chain, scan accumulators and output register
`timescale 1ns / 1ps
module swmc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmc_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic [swmc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_restart,
    input  logic                          i_out_ready,
    input  swmc_pkg::t_cmd                i_cmd,
    output swmc_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [swmc_pkg::COST_W-1:0]   o_cost
);
    import swmc_pkg::*;

    logic [SAMPLE_W-1:0] r_ring [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_ring_q;
    logic [SAMPLE_W-1:0] r_chain [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] n_chain [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_scan [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_samp;
    logic [SAMPLE_W-1:0] r_med;
    logic [CNT_W-1:0]    r_len;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_cnt;
    logic [PTR_W-1:0]    r_ptr;
    logic [COST_W-1:0]   r_lsum;
    logic [COST_W-1:0]   r_usum;
    logic [COST_W-1:0]   r_prod_l;
    logic [COST_W-1:0]   r_prod_u;
    logic [COST_W-1:0]   r_cost;

    logic [CNT_W-1:0]    lower;
    logic [CNT_W-1:0]    upper;
    logic [CNT_W:0]      fill_p1;
    logic [CNT_W:0]      ptr_p1;
    logic [CNT_W-1:0]    cfg_len;
    logic [PTR_W-1:0]    ptr_eff;
    logic [WINDOW_DEPTH-1:0] hit;
    logic [WINDOW_DEPTH-1:0] gt;
    logic [SAMPLE_W+CNT_W-1:0] prod_l;
    logic [SAMPLE_W+CNT_W-1:0] prod_u;

    assign fill_p1 = {1'b0, r_fill} + 1'b1;
    assign lower   = fill_p1[CNT_W:1];
    assign upper   = r_fill - lower;
    assign ptr_p1  = {{(CNT_W+1-PTR_W){1'b0}}, r_ptr} + 1'b1;
    assign prod_l  = lower * r_med;
    assign prod_u  = upper * r_med;

    always_comb begin
        // zero acts as one, anything above the depth acts as the depth
        if (i_cfg_data == '0) begin
            cfg_len = CNT_W'(1);
        end else if ({1'b0, i_cfg_data} > (LEN_W+1)'(WINDOW_DEPTH)) begin
            cfg_len = CNT_W'(WINDOW_DEPTH);
        end else begin
            cfg_len = CNT_W'(i_cfg_data);
        end
        if (i_restart || ({{(CNT_W-PTR_W){1'b0}}, r_ptr} >= r_len)) begin
            ptr_eff = '0;
        end else begin
            ptr_eff = r_ptr;
        end
    end

    // chain update: drop first match of the outgoing sample, or insert the new one
    always_comb begin
        hit = '0;
        gt  = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            gt[j] = (CNT_W'(j) < r_fill) && (r_chain[j] > r_samp);
            hit[j] = (CNT_W'(j) < r_fill) && (r_chain[j] == r_ring_q);
            if (j > 0) begin
                hit[j] = hit[j] | hit[(j > 0) ? j - 1 : 0];
            end
        end
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            n_chain[j] = r_chain[j];
            if (i_cmd.drop) begin
                if (hit[j] && j < WINDOW_DEPTH - 1) begin
                    n_chain[j] = r_chain[(j < WINDOW_DEPTH - 1) ? j + 1 : j];
                end
            end else if (i_cmd.insert) begin
                if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
                    n_chain[j] = r_chain[(j > 0) ? j - 1 : 0];
                end else if (gt[j] || CNT_W'(j) == r_fill) begin
                    n_chain[j] = r_samp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ring_q <= r_ring[ptr_eff];
        end
        if (i_cmd.insert) begin
            r_ring[r_ptr] <= r_samp;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            r_chain[j] <= n_chain[j];
            if (i_cmd.load) begin
                r_scan[j] <= r_chain[j];
            end else if (i_cmd.step) begin
                r_scan[j] <= r_scan[(j < WINDOW_DEPTH - 1) ? j + 1 : j];
            end
        end
        if (i_cmd.accept) begin
            r_samp <= i_sample;
        end
        if (i_cmd.load) begin
            r_lsum <= '0;
            r_usum <= '0;
        end else if (i_cmd.step) begin
            if (r_cnt < lower) begin
                r_lsum <= r_lsum + COST_W'(r_scan[0]);
            end else begin
                r_usum <= r_usum + COST_W'(r_scan[0]);
            end
            if (r_cnt == lower - 1'b1) begin
                r_med <= r_scan[0];
            end
        end
        if (i_cmd.mul) begin
            r_prod_l <= prod_l[COST_W-1:0];
            r_prod_u <= prod_u[COST_W-1:0];
        end
        if (i_cmd.sub) begin
            r_cost <= (r_prod_l - r_lsum) + (r_usum - r_prod_u);
        end
        if (i_cmd.emit) begin
            o_cost <= r_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= CNT_W'(WINDOW_DEPTH);
            r_fill      <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len  <= cfg_len;
                r_fill <= '0;
                r_ptr  <= '0;
            end else if (i_cmd.accept) begin
                r_ptr <= ptr_eff;
                if (i_restart) begin
                    r_fill <= '0;
                end
            end else if (i_cmd.drop) begin
                r_fill <= r_fill - 1'b1;
            end else if (i_cmd.insert) begin
                r_fill <= r_fill + 1'b1;
                r_ptr  <= (ptr_p1 >= {1'b0, r_len}) ? '0 : ptr_p1[PTR_W-1:0];
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.full      = (r_fill >= r_len);
    assign o_status.scan_done = (r_cnt == r_fill - 1'b1);
    assign o_status.out_busy  = o_out_valid && !i_out_ready;
endmodule

/* rtl/core/sliding_window_median_cost_top.sv */
// top level of the sliding window median cost block
//
// input channel: i_in_valid / o_in_ready carry one beat of i_sample and
// i_restart; restart empties the window before the sample is taken.
// output channel: o_out_valid / i_out_ready carry one beat of o_cost, the
// sum of absolute deviations of the window from its lower median, once the
// window holds window_length samples.
// one sample is worked at a time; the scan that forms the cost walks the
// sorted chain one entry a cycle.
// a finished cost sits in the output register while the next sample is
// taken; the block waits before emitting only if that beat is still held.
// i_cfg_we writes the window length (0 acts as 1, above 64 acts as 64) and
// empties the window. reset gives length 64, an empty window and no beat.
// stores need no clearing pass after reset.
`timescale 1ns / 1ps
module sliding_window_median_cost_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmc_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [swmc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [swmc_pkg::COST_W-1:0]   o_cost
);
    import swmc_pkg::*;

    t_cmd    cmd;
    t_status status;

    swmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    swmc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_restart   (i_restart),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_cost      (o_cost)
    );
endmodule

/* rtl/core/swmc_checker.sv */
// port level checks for the sliding window median cost block
`timescale 1ns / 1ps
module swmc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [swmc_pkg::COST_W-1:0]   o_cost
);
    import swmc_pkg::*;

    // a held result beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_cost)))
        else $error("result beat dropped or changed while stalled");

    // one sample at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous sample still in work");

    // a result beat never rises straight from idle: it needs an accepted sample first
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready, 1))
        else $error("result beat appeared straight from idle");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");
endmodule

bind sliding_window_median_cost_top swmc_checker u_swmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_cost      (o_cost)
);

/* tb/tb_sliding_window_median_cost_top.sv */
// self-checking testbench for the sliding window median cost block
`timescale 1ns / 1ps
module tb_sliding_window_median_cost_top;
    import swmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } t_beat;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [LEN_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [SAMPLE_W-1:0] i_sample;
    logic                i_restart;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [COST_W-1:0]   o_cost;

    sliding_window_median_cost_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cost      (o_cost)
    );

    // predictor state
    logic [SAMPLE_W-1:0] win_ring [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] win_sorted [WINDOW_DEPTH];
    int                  win_ptr;
    int                  win_fill;
    int                  win_len;

    t_beat             pending_beats[$];
    logic [COST_W-1:0] expected_costs[$];

    int  error_count;
    int  cost_count;
    int  sample_count;
    int  idle_cycles;
    bit  sender_jitter;
    bit  receiver_jitter;
    int  receiver_hold;
    bit  hold_req;
    bit  hold_done;
    bit  in_taken;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_len(input logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > WINDOW_DEPTH) return WINDOW_DEPTH;
        return int'(v);
    endfunction

    task automatic add_beat(input t_beat b);
        pending_beats = {pending_beats, b};
    endtask

    // push one sample through the window model, queue a cost once full
    task automatic predict_cost(input t_beat b);
        int          pos;
        int          lower;
        int          upper;
        logic [63:0] med;
        logic [63:0] lsum;
        logic [63:0] usum;
        logic [63:0] total;
        if (b.restart) begin
            win_ptr  = 0;
            win_fill = 0;
        end
        if (win_ptr >= win_len) win_ptr = 0;
        if (win_fill >= win_len) begin
            pos = 0;
            while (win_sorted[pos] != win_ring[win_ptr]) pos++;
            for (int j = pos; j + 1 < win_fill; j++) win_sorted[j] = win_sorted[j + 1];
            win_fill--;
        end
        pos = win_fill;
        while (pos > 0 && win_sorted[pos - 1] > b.sample) begin
            win_sorted[pos] = win_sorted[pos - 1];
            pos--;
        end
        win_sorted[pos] = b.sample;
        win_fill++;
        win_ring[win_ptr] = b.sample;
        win_ptr = (win_ptr + 1 >= win_len) ? 0 : win_ptr + 1;
        if (win_fill < win_len) return;
        lower = (win_fill + 1) / 2;
        upper = win_fill - lower;
        lsum  = 0;
        usum  = 0;
        for (int j = 0; j < win_fill; j++) begin
            if (j < lower) lsum += win_sorted[j];
            else usum += win_sorted[j];
        end
        med   = win_sorted[lower - 1];
        total = (lower * med - lsum) + (usum - upper * med);
        expected_costs = {expected_costs, total[COST_W-1:0]};
    endtask

    // input side sampling and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len  = WINDOW_DEPTH;
            win_ptr  = 0;
            win_fill = 0;
        end else if (i_cfg_we) begin
            win_len  = clamp_len(i_cfg_data);
            win_ptr  = 0;
            win_fill = 0;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_cost(t_beat'{sample: i_sample, restart: i_restart});
            void'(pending_beats.pop_front());
            sample_count++;
        end
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    // driver: present a beat, hold it until taken, then move on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_sample   <= '0;
            i_restart  <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_beats.size() != 0
                && !(sender_jitter && $urandom_range(99) < 17)) begin
                i_sample   <= pending_beats[0].sample;
                i_restart  <= pending_beats[0].restart;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready   <= 1'b0;
            receiver_hold <= 0;
            hold_done     <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            receiver_hold <= HOLD_CYCLES;
            i_out_ready   <= 1'b0;
        end else if (receiver_hold > 0) begin
            receiver_hold <= receiver_hold - 1;
            i_out_ready   <= 1'b0;
        end else begin
            i_out_ready <= !(receiver_jitter && $urandom_range(99) < 17);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [COST_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            cost_count++;
            if (expected_costs.size() == 0) begin
                $display("%0t: unexpected cost beat, actual %0d", $time, o_cost);
                error_count++;
            end else begin
                want = expected_costs.pop_front();
                if (o_cost !== want) begin
                    $display("%0t: cost mismatch, expected %0d actual %0d",
                             $time, want, o_cost);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("sliding_window_median_cost_top test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_costs.size() != 0) @(posedge i_clk);
        // an item with no beat may still be in progress
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(15));
            3: return SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_samples(input int n, input bit allow_restart);
        t_beat b;
        for (int k = 0; k < n; k++) begin
            b.sample  = rand_sample();
            b.restart = allow_restart && ($urandom_range(99) < 2);
            add_beat(b);
        end
    endtask

    initial begin
        logic [LEN_W-1:0] lens[] = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd127, 7'd5, 7'd64, 7'd65};
        sender_jitter = 1'b0; receiver_jitter = 1'b0; hold_req = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset length of 64, extremes, restart mid window
        for (int k = 0; k < 64; k++)
            add_beat(t_beat'{sample: (k % 2) ? '1 : '0, restart: 1'b0});
        add_beat(t_beat'{sample: '1, restart: 1'b0});
        wait_drained();
        set_length(7'd3);
        add_beat(t_beat'{sample: 30'd5, restart: 1'b0});
        add_beat(t_beat'{sample: '1, restart: 1'b0});
        add_beat(t_beat'{sample: 30'd0, restart: 1'b0});
        add_beat(t_beat'{sample: 30'd5, restart: 1'b0});
        add_beat(t_beat'{sample: 30'd9, restart: 1'b1});
        add_beat(t_beat'{sample: 30'd9, restart: 1'b0});
        add_beat(t_beat'{sample: 30'd1, restart: 1'b0});
        add_beat(t_beat'{sample: 30'd9, restart: 1'b0});

        // random phases, short windows mostly
        sender_jitter = 1'b1; receiver_jitter = 1'b1;
        foreach (lens[i]) begin
            set_length(lens[i]);
            queue_samples((clamp_len(lens[i]) > 8) ? 150 : 180, 1'b1);
            if (i == 2) begin
                // receiver backpressure long enough to stall the input side
                hold_req = 1'b1;
            end
            if (i == 5) begin
                sender_jitter = 1'b0; receiver_jitter = 1'b0;
            end
            if (i == 6) begin
                sender_jitter = 1'b1; receiver_jitter = 1'b1;
            end
        end
        set_length(7'd4);
        queue_samples(530, 1'b1);
        wait_drained();

        $display("covered %0d samples and %0d cost beats over window lengths 1 to 64",
                 sample_count, cost_count);
        if (error_count == 0)
            $display("sliding_window_median_cost_top test passed");
        else
            $display("sliding_window_median_cost_top test failed");
        $finish;
    end
endmodule
